// ===== hw/rtl/gini_best_split_search_assert.svh =====
// Assertion macros shared by the RTL of the Gini split search block.
`ifndef GINI_BEST_SPLIT_SEARCH_ASSERT_SVH
`define GINI_BEST_SPLIT_SEARCH_ASSERT_SVH
`ifndef SYNTHESIS
`define GBS_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define GBS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define GBS_ASSERT_IMPLY(lbl, ante, cons, msg)
`define GBS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/gbs_pkg.sv =====
// Package with constants, codes and types of the Gini split search block.
package gbs_pkg;
	localparam int MAX_FEATURES = 16;
	localparam int MAX_SAMPLES  = 1024;
	localparam int VALUE_WIDTH  = 32;

	localparam int FI_W   = $clog2(MAX_FEATURES);
	localparam int SI_W   = $clog2(MAX_SAMPLES);
	localparam int MULT_W = 11;
	localparam int NF_W   = 5;
	localparam int NS_W   = 11;
	localparam int CNT_W  = SI_W + MULT_W;
	localparam int PROD_W = 2 * CNT_W;
	localparam int ACC_W  = 3 * CNT_W + 1;
	localparam int GINI_W = 16;
	localparam int GSTEP_W = 5;
	localparam int CFG_IDX_W = 2;

	localparam int GINI_LAST_STEP = 17;
	localparam int DIV_LAST_STEP  = GINI_W - 1;

	localparam int S_FIELDS_W = FI_W + SI_W + VALUE_WIDTH + 1 + MULT_W;
	localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_FIELDS_W = 1 + FI_W + VALUE_WIDTH + GINI_W;
	localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_RUN  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_FEATURE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT  = 2'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MIN_SCAN,
		ST_NEXT_SCAN,
		ST_CNT_SCAN,
		ST_GINI,
		ST_DIV,
		ST_UPD,
		ST_FINISH
	} gbs_state_t;
endpackage

// ===== hw/rtl/gini_best_split_search.sv =====
// Top level of the Gini split search: sample store, scan sequencer and shared arithmetic.
//
// The block holds a value store of features by samples plus a label and a bootstrap
// multiplicity per sample. Requests arrive on the s_ channel: tuser selects a load
// (write one value, label and multiplicity) or a run (search for the best split).
// A run returns one result request on the m_ channel; a load returns nothing.
// Registers feature_count and sample_count are written over the cfg channel,
// which is always ready, and should be written only while the block is idle.
//
// Loads stream at one per cycle while the block is idle. A run walks the
// store through one RAM read port: per feature one scan finds the smallest value,
// then for every distinct value a scan finds the next larger one and, if there is
// one, a second scan counts the four weighted classes at the midpoint. A usable
// threshold then passes through the shared 21x21 multiplier, a restoring
// division and a compare step. The s_ channel is not ready while a run is in
// progress. A finished result waits in the output register for as long as the
// receiver stalls, and loads are still taken meanwhile. Reset returns to idle
// with the counts at 1 and 2; store contents are undefined until written and
// need no clearing pass.
`include "gini_best_split_search_assert.svh"
module gini_best_split_search (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// feature_index, sample_index, feature_value, class_label, boot_multiplicity
	input  logic [gbs_pkg::S_DATA_W-1:0]    s_tdata,
	// opcode
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// split_found, best_feature, best_threshold, best_gini
	output logic [gbs_pkg::M_DATA_W-1:0]    m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [gbs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gbs_pkg::NS_W-1:0]        cfg_data
);
	import gbs_pkg::*;

	localparam int FV_LSB = FI_W + SI_W;
	localparam int CL_BIT = FV_LSB + VALUE_WIDTH;
	localparam int BM_LSB = CL_BIT + 1;

	// Unpacked input request.
	logic [FI_W-1:0]        in_feature;
	logic [SI_W-1:0]        in_sample;
	logic [VALUE_WIDTH-1:0] in_value;
	logic                   in_label;
	logic [MULT_W-1:0]      in_mult;

	assign in_feature = s_tdata[FI_W-1:0];
	assign in_sample  = s_tdata[FV_LSB-1:FI_W];
	assign in_value   = s_tdata[CL_BIT-1:FV_LSB];
	assign in_label   = s_tdata[CL_BIT];
	assign in_mult    = s_tdata[BM_LSB+MULT_W-1:BM_LSB];

	gbs_state_t state_q, state_d;

	logic [NF_W-1:0] feature_count_q;
	logic [NS_W-1:0] sample_count_q;
	logic [NF_W-1:0] nf_eff;
	logic [NS_W-1:0] ns_eff;

	logic [NS_W-1:0]        j_q;
	logic                   rd_vld_s1;
	logic                   have_q;
	logic [FI_W-1:0]        f_q;
	logic [VALUE_WIDTH-1:0] cand_q, prev_q, thr_q;
	logic [CNT_W-1:0]       cnt_a_q, cnt_b_q, cnt_c_q, cnt_d_q;
	logic [CNT_W-1:0]       hi_sum, lo_sum, tot_sum;
	logic [GSTEP_W-1:0]     gstep_q;
	logic [PROD_W-1:0]      mp_q, x_q;
	logic [CNT_W-1:0]       mul_a, mul_b;
	logic [ACC_W-1:0]       num_q, den_q, rem_q, rem_dbl;
	logic                   div_ge;
	logic [GINI_W-1:0]      q_q;
	logic                   found_q;
	logic [FI_W-1:0]        best_f_q;
	logic [VALUE_WIDTH-1:0] best_thr_q;
	logic [GINI_W-1:0]      best_gini_q;
	logic                   m_tvalid_q;
	logic [M_DATA_W-1:0]    m_tdata_q;

	logic                   load_acc, run_acc, scanning, issue, scan_end, scan_start;
	logic                   last_feat, out_free;
	logic [VALUE_WIDTH-1:0] val_rdata, key;
	logic [MULT_W:0]        lm_rdata;
	logic [FI_W+SI_W-1:0]   val_addr;
	logic [SI_W-1:0]        lm_addr;

	assign nf_eff   = (feature_count_q > NF_W'(MAX_FEATURES)) ? NF_W'(MAX_FEATURES)
			: feature_count_q;
	assign ns_eff   = (sample_count_q > NS_W'(MAX_SAMPLES)) ? NS_W'(MAX_SAMPLES)
			: sample_count_q;
	assign scan_end = (j_q == ns_eff) && !rd_vld_s1;
	assign last_feat = (NF_W'(f_q) + NF_W'(1)) == nf_eff;
	assign out_free = !m_tvalid_q || m_tready;
	assign hi_sum   = cnt_a_q + cnt_b_q;
	assign lo_sum   = cnt_c_q + cnt_d_q;
	assign tot_sum  = hi_sum + lo_sum;
	// Stored values are compared with the sign bit flipped, so unsigned order is signed order.
	assign key      = {~val_rdata[VALUE_WIDTH-1], val_rdata[VALUE_WIDTH-2:0]};

	// Next-state logic of the run sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid && s_tuser == OP_RUN) begin
					state_d = (nf_eff == '0) ? ST_FINISH : ST_MIN_SCAN;
				end
			end
			ST_MIN_SCAN: begin
				if (scan_end) begin
					if (have_q) begin
						state_d = ST_NEXT_SCAN;
					end else begin
						state_d = last_feat ? ST_FINISH : ST_MIN_SCAN;
					end
				end
			end
			ST_NEXT_SCAN: begin
				if (scan_end) begin
					if (have_q) begin
						state_d = ST_CNT_SCAN;
					end else begin
						state_d = last_feat ? ST_FINISH : ST_MIN_SCAN;
					end
				end
			end
			ST_CNT_SCAN: begin
				if (scan_end) begin
					state_d = (hi_sum == '0 || lo_sum == '0) ? ST_NEXT_SCAN : ST_GINI;
				end
			end
			ST_GINI: begin
				if (gstep_q == GSTEP_W'(GINI_LAST_STEP)) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (gstep_q == GSTEP_W'(DIV_LAST_STEP)) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				state_d = ST_NEXT_SCAN;
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Handshake and memory control outputs.
	always_comb begin
		s_tready   = (state_q == ST_IDLE);
		cfg_ready  = 1'b1;
		load_acc   = s_tvalid && s_tready && (s_tuser == OP_LOAD);
		run_acc    = s_tvalid && s_tready && (s_tuser == OP_RUN);
		scanning   = (state_q == ST_MIN_SCAN) || (state_q == ST_NEXT_SCAN)
				|| (state_q == ST_CNT_SCAN);
		issue      = scanning && (j_q < ns_eff);
		scan_start = ((state_d == ST_MIN_SCAN) || (state_d == ST_NEXT_SCAN)
				|| (state_d == ST_CNT_SCAN)) && ((state_d != state_q) || scan_end);
		val_addr   = load_acc ? {in_feature, in_sample} : {f_q, j_q[SI_W-1:0]};
		lm_addr    = load_acc ? in_sample : j_q[SI_W-1:0];
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	gbs_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_FEATURES * MAX_SAMPLES)) u_value_ram (
		.clk   (clk),
		.we    (load_acc),
		.addr  (val_addr),
		.wdata (in_value),
		.rdata (val_rdata)
	);

	// Label in the top bit, multiplicity below it.
	gbs_ram #(.WIDTH(MULT_W + 1), .DEPTH(MAX_SAMPLES)) u_label_mult_ram (
		.clk   (clk),
		.we    (load_acc),
		.addr  (lm_addr),
		.wdata ({in_label, in_mult}),
		.rdata (lm_rdata)
	);

	// Operand selection of the shared multiplier: three products, each finished
	// from two 21-bit halves of a 42-bit partial product.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (gstep_q)
			5'd0:    begin mul_a = cnt_a_q;           mul_b = cnt_b_q; end
			5'd2:    begin mul_a = x_q[CNT_W-1:0];    mul_b = lo_sum;  end
			5'd4:    begin mul_a = x_q[PROD_W-1:CNT_W]; mul_b = lo_sum; end
			5'd6:    begin mul_a = cnt_c_q;           mul_b = cnt_d_q; end
			5'd8:    begin mul_a = x_q[CNT_W-1:0];    mul_b = hi_sum;  end
			5'd10:   begin mul_a = x_q[PROD_W-1:CNT_W]; mul_b = hi_sum; end
			5'd12:   begin mul_a = hi_sum;            mul_b = lo_sum;  end
			5'd14:   begin mul_a = x_q[CNT_W-1:0];    mul_b = tot_sum; end
			5'd16:   begin mul_a = x_q[PROD_W-1:CNT_W]; mul_b = tot_sum; end
			default: begin mul_a = '0;                mul_b = '0;      end
		endcase
	end

	assign rem_dbl = {rem_q[ACC_W-2:0], 1'b0};
	assign div_ge  = rem_dbl >= den_q;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			feature_count_q <= NF_W'(1);
			sample_count_q  <= NS_W'(2);
			j_q             <= '0;
			rd_vld_s1       <= 1'b0;
			have_q          <= 1'b0;
			gstep_q         <= '0;
			m_tvalid_q      <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_FEATURE_COUNT) begin
					feature_count_q <= cfg_data[NF_W-1:0];
				end else if (cfg_index == REG_SAMPLE_COUNT) begin
					sample_count_q <= cfg_data;
				end
			end
			if (scan_start) begin
				j_q    <= '0;
				have_q <= 1'b0;
			end else begin
				if (issue) begin
					j_q <= j_q + NS_W'(1);
				end
				if (rd_vld_s1) begin
					if (state_q == ST_MIN_SCAN && (!have_q || key < cand_q)) begin
						have_q <= 1'b1;
					end
					if (state_q == ST_NEXT_SCAN && key > prev_q
							&& (!have_q || key < cand_q)) begin
						have_q <= 1'b1;
					end
				end
			end
			if (state_d != state_q) begin
				gstep_q <= '0;
			end else if (state_q == ST_GINI || state_q == ST_DIV) begin
				gstep_q <= gstep_q + GSTEP_W'(1);
			end
			if (state_q == ST_FINISH && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		mp_q <= mul_a * mul_b;
		if (run_acc) begin
			f_q         <= '0;
			found_q     <= 1'b0;
			best_f_q    <= '0;
			best_thr_q  <= '0;
			best_gini_q <= '0;
		end
		if (state_q == ST_CNT_SCAN && scan_start) begin
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			cnt_c_q <= '0;
			cnt_d_q <= '0;
		end
		if (state_d == ST_CNT_SCAN && state_q != ST_CNT_SCAN) begin
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			cnt_c_q <= '0;
			cnt_d_q <= '0;
		end
		if (rd_vld_s1) begin
			unique case (state_q)
				ST_MIN_SCAN: begin
					if (!have_q || key < cand_q) begin
						cand_q <= key;
					end
				end
				ST_NEXT_SCAN: begin
					if (key > prev_q && (!have_q || key < cand_q)) begin
						cand_q <= key;
					end
				end
				ST_CNT_SCAN: begin
					if (key >= thr_q) begin
						if (lm_rdata[MULT_W]) begin
							cnt_b_q <= cnt_b_q + CNT_W'(lm_rdata[MULT_W-1:0]);
						end else begin
							cnt_a_q <= cnt_a_q + CNT_W'(lm_rdata[MULT_W-1:0]);
						end
					end else begin
						if (lm_rdata[MULT_W]) begin
							cnt_d_q <= cnt_d_q + CNT_W'(lm_rdata[MULT_W-1:0]);
						end else begin
							cnt_c_q <= cnt_c_q + CNT_W'(lm_rdata[MULT_W-1:0]);
						end
					end
				end
				default: begin
				end
			endcase
		end
		if (scan_end && (state_q == ST_MIN_SCAN || state_q == ST_NEXT_SCAN)) begin
			if (have_q) begin
				prev_q <= cand_q;
				if (state_q == ST_NEXT_SCAN) begin
					thr_q <= prev_q + ((cand_q - prev_q) >> 1);
				end
			end else begin
				f_q <= f_q + FI_W'(1);
			end
		end
		if (state_q == ST_GINI) begin
			unique case (gstep_q)
				5'd1, 5'd7, 5'd13: x_q <= mp_q;
				5'd3:              num_q <= ACC_W'(mp_q);
				5'd9:              num_q <= num_q + ACC_W'(mp_q);
				5'd5, 5'd11:       num_q <= num_q + (ACC_W'(mp_q) << CNT_W);
				5'd15:             den_q <= ACC_W'(mp_q);
				5'd17: begin
					den_q <= den_q + (ACC_W'(mp_q) << CNT_W);
					rem_q <= {num_q[ACC_W-2:0], 1'b0};
					q_q   <= '0;
				end
				default: begin
				end
			endcase
		end
		if (state_q == ST_DIV) begin
			rem_q <= div_ge ? rem_dbl - den_q : rem_dbl;
			q_q   <= {q_q[GINI_W-2:0], div_ge};
		end
		if (state_q == ST_UPD && (!found_q || q_q < best_gini_q)) begin
			found_q     <= 1'b1;
			best_f_q    <= f_q;
			best_thr_q  <= {~thr_q[VALUE_WIDTH-1], thr_q[VALUE_WIDTH-2:0]};
			best_gini_q <= q_q;
		end
		if (state_q == ST_FINISH && out_free) begin
			m_tdata_q <= M_DATA_W'({best_gini_q, best_thr_q, best_f_q, found_q});
		end
	end

	`GBS_ASSERT_IMPLY(a_div_rem_below_den, state_q == ST_DIV, rem_q < den_q,
		"division remainder reached the divisor")
	`GBS_ASSERT_IMPLY(a_gini_in_range, state_q == ST_UPD, q_q <= GINI_W'(32768),
		"impurity quotient above one half")
	`GBS_ASSERT_IMPLY(a_scan_index_bound, scanning, j_q <= ns_eff,
		"scan index ran past the sample count")
	`GBS_ASSERT_NEXT(a_gini_sides_nonempty, state_q == ST_CNT_SCAN && state_d == ST_GINI,
		hi_sum != '0 && lo_sum != '0, "impurity started with an empty side")
	`GBS_ASSERT_NEXT(a_finish_holds, state_q == ST_FINISH && m_tvalid_q && !m_tready,
		state_q == ST_FINISH, "run result dropped while the output was full")
endmodule

// ===== hw/rtl/gbs_ram.sv =====
// Generic single-port RAM with registered read data.
module gbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ===== sim/gini_best_split_search_tb.sv =====
// Self-checking testbench for the Gini split search block: scoreboard, drivers and test flow.
`timescale 1ns / 100ps

typedef struct packed {
	logic [15:0] gini;
	logic [31:0] threshold;
	logic [3:0]  feature;
	logic        found;
} split_result_t;

class split_scoreboard;
	// Values are kept with the sign bit flipped so that unsigned order is signed order.
	logic [31:0] keyed_value [gbs_pkg::MAX_FEATURES*gbs_pkg::MAX_SAMPLES];
	logic        label_of [gbs_pkg::MAX_SAMPLES];
	logic [10:0] weight_of [gbs_pkg::MAX_SAMPLES];
	logic [4:0]  feature_count;
	logic [10:0] sample_count;
	split_result_t pending_splits[$];
	int mismatches;
	int results_checked;

	function new();
		feature_count = 1;
		sample_count = 2;
		mismatches = 0;
		results_checked = 0;
	endfunction

	function void write_reg(logic [1:0] idx, logic [10:0] data);
		if (idx == gbs_pkg::REG_FEATURE_COUNT)
			feature_count = data[4:0];
		else if (idx == gbs_pkg::REG_SAMPLE_COUNT)
			sample_count = data;
	endfunction

	// Exact weighted Gini, truncated to Q0.16.
	function logic [15:0] gini_q16(logic [127:0] a, logic [127:0] b,
			logic [127:0] c, logic [127:0] d);
		logic [127:0] num;
		logic [127:0] den;
		num = (a * b * (c + d) + c * d * (a + b)) * 2 * 65536;
		den = (a + b) * (c + d) * (a + b + c + d);
		return 16'(num / den);
	endfunction

	function split_result_t predict_split();
		split_result_t best;
		logic [31:0] sorted[$];
		logic [31:0] lo, hi, thr, key;
		logic [127:0] a, b, c, d;
		logic [15:0] g;
		int nf, ns, j;
		best = '0;
		nf = (feature_count < gbs_pkg::MAX_FEATURES) ? feature_count : gbs_pkg::MAX_FEATURES;
		ns = (sample_count < gbs_pkg::MAX_SAMPLES) ? sample_count : gbs_pkg::MAX_SAMPLES;
		for (int f = 0; f < nf; f++) begin
			sorted.delete();
			for (int i = 0; i < ns; i++)
				sorted.insert(sorted.size(), keyed_value[f*gbs_pkg::MAX_SAMPLES + i]);
			sorted.sort();
			for (int i = 1; i < ns; i++) begin
				lo = sorted[i-1];
				hi = sorted[i];
				if (hi == lo)
					continue;
				thr = lo + ((hi - lo) >> 1);
				a = 0; b = 0; c = 0; d = 0;
				for (j = 0; j < ns; j++) begin
					key = keyed_value[f*gbs_pkg::MAX_SAMPLES + j];
					if (key >= thr) begin
						if (label_of[j]) b += weight_of[j]; else a += weight_of[j];
					end else begin
						if (label_of[j]) d += weight_of[j]; else c += weight_of[j];
					end
				end
				if (a + b == 0 || c + d == 0)
					continue;
				g = gini_q16(a, b, c, d);
				if (!best.found || g < best.gini) begin
					best.found = 1'b1;
					best.feature = 4'(f);
					best.threshold = thr ^ 32'h8000_0000;
					best.gini = g;
				end
			end
		end
		return best;
	endfunction

	function void note_request(logic op, logic [3:0] fi, logic [9:0] si, logic [31:0] value,
			logic lbl, logic [10:0] weight);
		if (op == gbs_pkg::OP_LOAD) begin
			keyed_value[{fi, si}] = value ^ 32'h8000_0000;
			label_of[si] = lbl;
			weight_of[si] = weight;
		end else begin
			pending_splits.insert(pending_splits.size(), predict_split());
		end
	endfunction

	function void check_result(split_result_t got);
		split_result_t want;
		results_checked++;
		if (pending_splits.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Unexpected result request: %p", got);
			return;
		end
		want = pending_splits.pop_front();
		if (got.found !== want.found || got.feature !== want.feature ||
				got.threshold !== want.threshold || got.gini !== want.gini) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Result mismatch: expected found=%0b feature=%0d thr=%h gini=%0d,",
					want.found, want.feature, want.threshold, want.gini,
					" got found=%0b feature=%0d thr=%h gini=%0d",
					got.found, got.feature, got.threshold, got.gini);
		end
	endfunction
endclass

module gini_best_split_search_tb;
	import gbs_pkg::*;

	// The limit stays well above the longest correct run here.
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int RX_HOLD_CYCLES = 3000;
	localparam int ITEM_TARGET = 1750;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [NS_W-1:0] cfg_data = '0;

	split_scoreboard split_sb;
	int cycle_count = 0;
	int loads_sent = 0;
	int runs_sent = 0;
	bit hold_rx = 0;       // sender asks the receiver for one long stall
	bit steady = 0;        // phases with no idling on either side
	logic [31:0] value_pool [4];

	gini_best_split_search u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Values lean on a small per-phase pool so that duplicates and ties are common.
	function automatic logic [31:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 32'h8000_0000;
		if (r == 1) return 32'h7fff_ffff;
		if (r < 7) return value_pool[$urandom_range(0, 3)];
		return $urandom();
	endfunction

	function automatic logic [10:0] pick_weight();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return 11'd0;
		if (r == 1) return 11'd1024;
		if (r == 2) return 11'd1023;
		if (r < 6) return 11'($urandom_range(0, 1024));
		return 11'($urandom_range(0, 8));
	endfunction

	// Drives one request and waits for the handshake. A gap, if any, follows here
	// and the next request in the caller, so tvalid gets one assignment per edge.
	task automatic send_request(logic op, logic [3:0] fi, logic [9:0] si, logic [31:0] value,
			logic lbl, logic [10:0] weight);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {6'd0, weight, lbl, value, si, fi};
		do @(posedge clk); while (!s_tready);
		split_sb.note_request(op, fi, si, value, lbl, weight);
		if (op == OP_LOAD) loads_sent++; else runs_sent++;
		begin
			int g;
			g = gap_len();
			if (g > 0) begin
				s_tvalid <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	endtask

	task automatic load_cell(int fi, int si);
		send_request(OP_LOAD, 4'(fi), 10'(si), pick_value(), 1'($urandom_range(0, 1)),
			pick_weight());
	endtask

	task automatic start_search();
		send_request(OP_RUN, 4'($urandom()), 10'($urandom()), $urandom(),
			1'($urandom_range(0, 1)), 11'($urandom_range(0, 1024)));
	endtask

	// Pause the sender until every expected result is back, then let the block settle.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (split_sb.pending_splits.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [NS_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		split_sb.write_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_counts(int nf, int ns);
		wait_drained();
		write_reg(REG_FEATURE_COUNT, NS_W'(nf));
		write_reg(REG_SAMPLE_COUNT, NS_W'(ns));
	endtask

	task automatic new_pool();
		foreach (value_pool[k])
			value_pool[k] = ($urandom_range(0, 1)) ? $urandom() : 32'($urandom_range(0, 255)) - 128;
	endtask

	// One random phase: fill every cell a search reads, then search, then
	// rewrite a few cells and search again.
	task automatic random_phase(int nf, int ns, bit pressure);
		set_counts(nf, ns);
		new_pool();
		steady = ($urandom_range(0, 4) == 0);
		for (int f = 0; f < nf; f++)
			for (int s = 0; s < ns; s++)
				load_cell(f, s);
		if (pressure)
			hold_rx = 1;
		start_search();
		for (int k = 0; k < $urandom_range(1, 2); k++) begin
			for (int n = 0; n < $urandom_range(1, 6); n++)
				load_cell($urandom_range(0, nf - 1), $urandom_range(0, ns - 1));
			// Occasional stray load on any feature, possibly outside the searched range.
			if ($urandom_range(0, 2) == 0)
				load_cell($urandom_range(0, 15), $urandom_range(0, ns - 1));
			start_search();
		end
	endtask

	// Receiver: random stalls, plus one long hold-off when the sender asks for it.
	initial begin
		int stall_left;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			if (hold_rx) begin
				hold_rx = 0;
				m_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
			end else begin
				if (stall_left > 0) begin
					stall_left--;
					m_tready <= 1'b0;
				end else if (steady || $urandom_range(0, 99) < 70) begin
					m_tready <= 1'b1;
				end else begin
					stall_left = gap_len();
					m_tready <= 1'b0;
				end
				@(posedge clk);
				if (m_tvalid && m_tready)
					split_sb.check_result(split_result_t'(m_tdata[M_FIELDS_W-1:0]));
			end
		end
	end

	initial begin
		split_sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Extreme values on both sides of a two-sample store,
		// with the largest weight and the widest spread.
		value_pool = '{32'd0, 32'd1, -32'd1, 32'h0001_0000};
		send_request(OP_LOAD, 4'd0, 10'd0, 32'h8000_0000, 1'b0, 11'd1024);
		send_request(OP_LOAD, 4'd0, 10'd1, 32'h7fff_ffff, 1'b1, 11'd1023);
		start_search();
		// Two equal values: no threshold at all.
		send_request(OP_LOAD, 4'd0, 10'd1, 32'h8000_0000, 1'b1, 11'd5);
		start_search();
		// Distinct values but every weight zero: both sides empty.
		send_request(OP_LOAD, 4'd0, 10'd0, 32'd7, 1'b0, 11'd0);
		send_request(OP_LOAD, 4'd0, 10'd1, -32'd7, 1'b1, 11'd0);
		start_search();
		// Ties: three samples whose two thresholds give the same impurity.
		set_counts(1, 3);
		send_request(OP_LOAD, 4'd0, 10'd0, 32'd0, 1'b0, 11'd1);
		send_request(OP_LOAD, 4'd0, 10'd1, 32'd10, 1'b1, 11'd1);
		send_request(OP_LOAD, 4'd0, 10'd2, 32'd20, 1'b0, 11'd1);
		start_search();
		// Zero feature count searches nothing, a single sample has no pair, and
		// counts above the store size are clamped.
		set_counts(0, 3);
		start_search();
		set_counts(1, 1);
		start_search();
		set_counts(1, 0);
		start_search();
		wait_drained();
		write_reg(REG_FEATURE_COUNT, 11'h7f0);   // low five bits give 16
		write_reg(REG_SAMPLE_COUNT, 11'd2);
		for (int f = 0; f < 16; f++)
			for (int s = 0; s < 2; s++)
				load_cell(f, s);
		start_search();
		set_counts(31, 2);
		start_search();

		// Full store depth on one feature with few distinct values, then clamped.
		new_pool();
		set_counts(1, 1024);
		for (int s = 0; s < 1024; s++)
			send_request(OP_LOAD, 4'd0, 10'(s), value_pool[$urandom_range(0, 2)],
				1'($urandom_range(0, 1)), pick_weight());
		start_search();
		set_counts(1, 2047);
		start_search();

		// Long receiver hold-off while runs and loads keep coming.
		random_phase(2, 6, 1'b1);

		// Random phases, mostly small.
		while (loads_sent + runs_sent < ITEM_TARGET || runs_sent < 60) begin
			if ($urandom_range(0, 15) == 0)
				random_phase(1, $urandom_range(24, 48), 1'b0);
			else
				random_phase($urandom_range(1, 4), $urandom_range(2, 10), 1'b0);
		end

		wait_drained();
		repeat (50) @(posedge clk);
		$display("Covered %0d loads and %0d searches; %0d results checked, %0d mismatches.",
			loads_sent, runs_sent, split_sb.results_checked, split_sb.mismatches);
		if (split_sb.mismatches == 0 && split_sb.pending_splits.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
